// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the buffer sorter.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must hold on every clock edge outside reset.
`define QS_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define QS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define QS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define QS_ASSERT(lbl, clk, rst_n, cond, msg)
`define QS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define QS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/qsort_pkg.sv -----
// Shared types and constants of the quicksort buffer sorter.
// No dependencies; imported by the controller, the datapath and the top level.
package qsort_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_W          = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] element_value;
        logic                      last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_of_run;
        logic                      overflowed;
    } t_out_item;

    // Datapath commands issued by the controller
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_INIT,
        OP_POP_RD,
        OP_POP_LD,
        OP_PIV_LD,
        OP_J_RD,
        OP_J_CMP,
        OP_SW1,
        OP_SW2,
        OP_FIN_RD,
        OP_FIN_W1,
        OP_FIN_W2,
        OP_PUSH_R,
        OP_PUSH_L,
        OP_EMIT,
        OP_CLEAR
    } t_dp_op;

    typedef struct packed {
        logic less;
        logic j_next_hi;
        logic range_ok;
        logic stack_empty;
        logic emit_last;
        logic count_zero;
        logic count_lt2;
    } t_dp_status;

endpackage

// ----- hw/rtl/qsort_dp.sv -----
// Datapath of the buffer sorter: element memory, range stack, partition registers.
// Depends on qsort_pkg and assert_macros.svh; driven by qsort_ctrl commands.
`include "assert_macros.svh"
module qsort_dp import qsort_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_op     i_op,
    input  t_in_item   i_item,
    output t_dp_status o_status,
    output logic       o_strobe,
    output t_out_item  o_result
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int RNG_W = 2 * IDX_W;

    logic [VALUE_W-1:0] r_mem [MAX_ELEMENTS];
    logic [RNG_W-1:0]   r_stk [MAX_ELEMENTS];

    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_sp, n_sp;
    logic               r_ovf, n_ovf;
    logic [IDX_W-1:0]   r_k, n_k;
    logic               r_emit_v, n_emit_v;
    logic               r_emit_last, n_emit_last;
    logic [IDX_W-1:0]   r_lo, n_lo;
    logic [IDX_W-1:0]   r_hi, n_hi;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [IDX_W-1:0]   r_slot, n_slot;
    logic [VALUE_W-1:0] r_pivot, n_pivot;
    logic [VALUE_W-1:0] r_aj, n_aj;
    logic [VALUE_W-1:0] r_rdata;
    logic [RNG_W-1:0]   r_stk_rd;

    logic               w_we, w_re;
    logic [IDX_W-1:0]   w_waddr, w_raddr;
    logic [VALUE_W-1:0] w_wdata;
    logic               w_push, w_pop;
    logic [RNG_W-1:0]   w_push_data;

    logic [IDX_W-1:0]   w_stk_lo, w_stk_hi;
    logic [CNT_W-1:0]   w_sp_dec, w_cnt_dec;
    logic [IDX_W:0]     w_slot_inc, w_lo_inc, w_j_inc;
    logic [IDX_W-1:0]   w_slot_dec;
    logic               w_has_room, w_stk_room, w_push_r_ok, w_push_l_ok;

    assign w_stk_lo    = r_stk_rd[IDX_W-1:0];
    assign w_stk_hi    = r_stk_rd[RNG_W-1:IDX_W];
    assign w_sp_dec    = r_sp - CNT_W'(1);
    assign w_cnt_dec   = r_count - CNT_W'(1);
    assign w_slot_inc  = {1'b0, r_slot} + (IDX_W+1)'(1);
    assign w_lo_inc    = {1'b0, r_lo} + (IDX_W+1)'(1);
    assign w_j_inc     = {1'b0, r_j} + (IDX_W+1)'(1);
    assign w_slot_dec  = r_slot - IDX_W'(1);
    assign w_has_room  = (r_count < CNT_W'(MAX_ELEMENTS));
    assign w_stk_room  = (r_sp < CNT_W'(MAX_ELEMENTS));
    assign w_push_r_ok = (w_slot_inc < {1'b0, r_hi});
    assign w_push_l_ok = ({1'b0, r_slot} > w_lo_inc);

    assign o_status.less        = ($signed(r_rdata) < $signed(r_pivot));
    assign o_status.j_next_hi   = (w_j_inc == {1'b0, r_hi});
    assign o_status.range_ok    = (w_stk_lo < w_stk_hi);
    assign o_status.stack_empty = (r_sp == '0);
    assign o_status.emit_last   = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);
    assign o_status.count_zero  = (r_count == '0);
    assign o_status.count_lt2   = (r_count < CNT_W'(2));

    assign o_strobe                = r_emit_v;
    assign o_result.sorted_value   = $signed(r_rdata);
    assign o_result.last_of_run    = r_emit_last;
    assign o_result.overflowed     = r_ovf;

    // Memory port and register next-state selection per command
    always_comb begin
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_waddr     = r_j;
        w_raddr     = r_j;
        w_wdata     = r_rdata;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_push_data = {r_hi, r_lo};
        n_count     = r_count;
        n_sp        = r_sp;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_emit_v    = 1'b0;
        n_emit_last = r_emit_last;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_j         = r_j;
        n_slot      = r_slot;
        n_pivot     = r_pivot;
        n_aj        = r_aj;
        unique case (i_op)
            OP_IDLE: begin
            end
            OP_LOAD: begin
                if (w_has_room) begin
                    w_we    = 1'b1;
                    w_waddr = r_count[IDX_W-1:0];
                    w_wdata = i_item.element_value;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
            OP_INIT: begin
                w_push      = w_stk_room;
                w_push_data = {w_cnt_dec[IDX_W-1:0], IDX_W'(0)};
                if (w_stk_room) n_sp = r_sp + CNT_W'(1);
            end
            OP_POP_RD: begin
                w_pop = 1'b1;
                n_sp  = w_sp_dec;
            end
            OP_POP_LD: begin
                n_lo    = w_stk_lo;
                n_hi    = w_stk_hi;
                n_j     = w_stk_lo;
                n_slot  = w_stk_lo;
                w_re    = 1'b1;
                w_raddr = w_stk_hi;
            end
            OP_PIV_LD: begin
                n_pivot = r_rdata;
            end
            OP_J_RD: begin
                w_re    = 1'b1;
                w_raddr = r_j;
            end
            OP_J_CMP: begin
                if (o_status.less) begin
                    n_aj    = r_rdata;
                    w_re    = 1'b1;
                    w_raddr = r_slot;
                end else begin
                    n_j = w_j_inc[IDX_W-1:0];
                end
            end
            OP_SW1: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_rdata;
            end
            OP_SW2: begin
                w_we    = 1'b1;
                w_waddr = r_slot;
                w_wdata = r_aj;
                n_slot  = w_slot_inc[IDX_W-1:0];
                n_j     = w_j_inc[IDX_W-1:0];
            end
            OP_FIN_RD: begin
                w_re    = 1'b1;
                w_raddr = r_slot;
            end
            OP_FIN_W1: begin
                w_we    = 1'b1;
                w_waddr = r_hi;
                w_wdata = r_rdata;
            end
            OP_FIN_W2: begin
                w_we    = 1'b1;
                w_waddr = r_slot;
                w_wdata = r_pivot;
            end
            OP_PUSH_R: begin
                w_push      = w_push_r_ok && w_stk_room;
                w_push_data = {r_hi, w_slot_inc[IDX_W-1:0]};
                if (w_push) n_sp = r_sp + CNT_W'(1);
            end
            OP_PUSH_L: begin
                w_push      = w_push_l_ok && w_stk_room;
                w_push_data = {w_slot_dec, r_lo};
                if (w_push) n_sp = r_sp + CNT_W'(1);
            end
            OP_EMIT: begin
                w_re        = 1'b1;
                w_raddr     = r_k;
                n_emit_v    = 1'b1;
                n_emit_last = o_status.emit_last;
                n_k         = r_k + IDX_W'(1);
            end
            OP_CLEAR: begin
                n_count = '0;
                n_sp    = '0;
                n_ovf   = 1'b0;
                n_k     = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sp     <= '0;
            r_ovf    <= 1'b0;
            r_k      <= '0;
            r_emit_v <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_sp     <= n_sp;
            r_ovf    <= n_ovf;
            r_k      <= n_k;
            r_emit_v <= n_emit_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit_last <= n_emit_last;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_j         <= n_j;
        r_slot      <= n_slot;
        r_pivot     <= n_pivot;
        r_aj        <= n_aj;
    end

    // Element memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_re) r_rdata <= r_mem[w_raddr];
    end

    // Range stack memory
    always_ff @(posedge i_clk) begin
        if (w_push) r_stk[r_sp[IDX_W-1:0]] <= w_push_data;
        if (w_pop) r_stk_rd <= r_stk[w_sp_dec[IDX_W-1:0]];
    end

    `QS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_ELEMENTS), "count beyond capacity")
    `QS_ASSERT(a_sp_bound, i_clk, i_rst_n, r_sp <= CNT_W'(MAX_ELEMENTS), "stack pointer beyond depth")
    `QS_ASSERT_IMP(a_slot_le_j, i_clk, i_rst_n, i_op == OP_SW2, r_slot <= r_j, "slot ahead of scan")
    `QS_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, r_emit_v && r_emit_last, !r_emit_v, "word after last")

endmodule

// ----- hw/rtl/qsort_ctrl.sv -----
// Controller of the buffer sorter: sequences load, partition passes and emission.
// Depends on qsort_pkg and assert_macros.svh; commands qsort_dp.
`include "assert_macros.svh"
module qsort_ctrl import qsort_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_last,
    input  t_dp_status i_status,
    output t_dp_op     o_op,
    output logic       o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_POP,
        S_POP_LD,
        S_PIV_LD,
        S_J_RD,
        S_J_CMP,
        S_SW1,
        S_SW2,
        S_FIN_RD,
        S_FIN_W1,
        S_FIN_W2,
        S_PUSH_R,
        S_PUSH_L,
        S_EMIT,
        S_DRAIN
    } t_state;

    t_state r_state, n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = OP_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op = OP_LOAD;
                    if (i_last) n_state = S_START;
                end
            end
            S_START: begin
                if (i_status.count_zero) begin
                    n_state = S_DRAIN;
                end else if (i_status.count_lt2) begin
                    n_state = S_EMIT;
                end else begin
                    o_op    = OP_INIT;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_status.stack_empty) begin
                    n_state = S_EMIT;
                end else begin
                    o_op    = OP_POP_RD;
                    n_state = S_POP_LD;
                end
            end
            S_POP_LD: begin
                o_op    = OP_POP_LD;
                n_state = i_status.range_ok ? S_PIV_LD : S_POP;
            end
            S_PIV_LD: begin
                o_op    = OP_PIV_LD;
                n_state = S_J_RD;
            end
            S_J_RD: begin
                o_op    = OP_J_RD;
                n_state = S_J_CMP;
            end
            S_J_CMP: begin
                o_op = OP_J_CMP;
                if (i_status.less) n_state = S_SW1;
                else if (i_status.j_next_hi) n_state = S_FIN_RD;
                else n_state = S_J_RD;
            end
            S_SW1: begin
                o_op    = OP_SW1;
                n_state = S_SW2;
            end
            S_SW2: begin
                o_op    = OP_SW2;
                n_state = i_status.j_next_hi ? S_FIN_RD : S_J_RD;
            end
            S_FIN_RD: begin
                o_op    = OP_FIN_RD;
                n_state = S_FIN_W1;
            end
            S_FIN_W1: begin
                o_op    = OP_FIN_W1;
                n_state = S_FIN_W2;
            end
            S_FIN_W2: begin
                o_op    = OP_FIN_W2;
                n_state = S_PUSH_R;
            end
            S_PUSH_R: begin
                o_op    = OP_PUSH_R;
                n_state = S_PUSH_L;
            end
            S_PUSH_L: begin
                o_op    = OP_PUSH_L;
                n_state = S_POP;
            end
            S_EMIT: begin
                o_op = OP_EMIT;
                if (i_status.emit_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                // last word is on the outputs now; drop the set
                o_op    = OP_CLEAR;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `QS_ASSERT_NXT(a_last_starts, i_clk, i_rst_n, i_start && !o_busy && i_last, r_state == S_START, "sort not started")
    `QS_ASSERT_NXT(a_swap_pair, i_clk, i_rst_n, r_state == S_SW1, r_state == S_SW2, "swap split")
    `QS_ASSERT_NXT(a_fin_push, i_clk, i_rst_n, r_state == S_FIN_W2, r_state == S_PUSH_R, "pivot placed, no push")

endmodule

// ----- hw/rtl/quicksort_buffer_sorter.sv -----
// Buffer sorter: loads one word per cycle (start while not busy), sorts on the last word.
// Each partition of a range reads, compares and swaps its words one at a time, bounded by
// the single read / single write port of the element memory; no clearing pass.
// Results are registered and follow one per cycle during emission, n words then a drain state.
// Synchronous active-low reset clears count, stack pointer, overflow flag, emit index, strobe and sequencer state.
// Results are strobed for one cycle each; the receiver cannot stall.
module quicksort_buffer_sorter import qsort_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_dp_op     w_op;
    t_dp_status w_status;

    qsort_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_item.last_element),
        .i_status (w_status),
        .o_op     (w_op),
        .o_busy   (busy)
    );

    qsort_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op),
        .i_item   (i_item),
        .o_status (w_status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
